// ===== rtl/tnmd_pkg.sv =====
// Shared types and constants for the tree nearest-marked distance block.
// No dependencies; used by every file under rtl/ except tnmd_ram.
package tnmd_pkg;

  localparam int KIND_W = 2;
  localparam int NODE_W = 10;
  localparam int DIST_W = 10;
  localparam int CFG_W  = 11;

  localparam logic [KIND_W-1:0] KIND_EDGE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PAINT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  localparam logic [DIST_W-1:0] DIST_MAX = 10'd1023;
  localparam logic [CFG_W-1:0]  NODES_MIN = 11'd2;

  typedef enum logic [23:0] {
    S_CLR    = 24'h000001,
    S_IDLE   = 24'h000002,
    B_POP    = 24'h000004,
    B_CUR    = 24'h000008,
    B_SCAN   = 24'h000010,
    B_EDGE   = 24'h000020,
    B_EDGE2  = 24'h000040,
    B_SEEN   = 24'h000080,
    F_A      = 24'h000100,
    F_B      = 24'h000200,
    F_C      = 24'h000400,
    Q_START  = 24'h000800,
    Q_DA     = 24'h001000,
    Q_V      = 24'h002000,
    Q_P      = 24'h004000,
    Q_LIFT   = 24'h008000,
    Q_LIFT_W = 24'h010000,
    Q_CMP    = 24'h020000,
    Q_CMP2   = 24'h040000,
    Q_CMP_W  = 24'h080000,
    Q_PAR    = 24'h100000,
    Q_PAR_W  = 24'h200000,
    Q_AD     = 24'h400000,
    Q_AD_W   = 24'h800000
  } state_t;

endpackage

// ===== rtl/tnmd_ram.sv =====
// Simple dual-port RAM: one write port, one registered read port.
// Depends on nothing; instantiated by tree_nearest_marked_distance.
module tnmd_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 4,
  parameter int DEPTH  = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tree_nearest_marked_distance.sv =====
// Top level: nearest painted node distance on a tree via binary lifting.
// Depends on tnmd_pkg and tnmd_ram.
//
//   channel  direction  handshake          payload
//   in       to block   in_valid/in_stall  kind, node_a, node_b
//   out      from block out_valid/out_stall distance
//   cfg      to block   cfg_we             cfg_wdata (node_count)
//
// Sequence: after reset a clearing pass over all MAX_NODES entries runs
// before any request is taken. Edge and paint requests are taken in the
// idle state. The last edge starts a depth-first build that scans the edge
// list from each node's saved cursor and pushes one unseen neighbour per
// stack frame visit, then fills the ancestor table level by level. A query
// scans every node and measures each painted one through the single
// ancestor RAM read port.
// Reset is synchronous; a finished result waits in the output register
// while the next request is taken.
module tree_nearest_marked_distance #(
  parameter int MAX_NODES   = 1024,
  parameter int LIFT_LEVELS = 11
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [tnmd_pkg::KIND_W-1:0] kind,
  input  logic [tnmd_pkg::NODE_W-1:0] node_a,
  input  logic [tnmd_pkg::NODE_W-1:0] node_b,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tnmd_pkg::DIST_W-1:0] distance,
  input  logic                        cfg_we,
  input  logic [tnmd_pkg::CFG_W-1:0]  cfg_wdata
);

  localparam int NW  = $clog2(MAX_NODES);
  localparam int CW  = $clog2(MAX_NODES + 1);
  localparam int AW  = NW + 1;
  localparam int LW  = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
  localparam int LCW = $clog2(LIFT_LEVELS + 1);
  localparam int XW  = (CW > tnmd_pkg::CFG_W) ? CW : tnmd_pkg::CFG_W;
  localparam int DSW = (NW + 2 > tnmd_pkg::DIST_W + 1) ? NW + 2 : tnmd_pkg::DIST_W + 1;
  localparam int ANC_DEPTH = LIFT_LEVELS * (2 ** NW);
  localparam logic [AW-1:0] NONE = AW'(MAX_NODES);

  tnmd_pkg::state_t state;

  // control
  logic [CW-1:0]  node_count;
  logic [NW-1:0]  edges;
  logic           ready;
  logic [CW-1:0]  top;
  logic [CW-1:0]  idx;
  logic [LCW-1:0] lvl;
  // payload / working registers
  logic [NW-1:0]  cur, scan, dcur, wnode, qa, da, du, dd, k;
  logic [AW-1:0]  pu, pv, xa, la;
  logic [tnmd_pkg::DIST_W-1:0] best;

  // RAM ports
  logic              edge_we;   logic [NW-1:0] edge_wa, edge_ra;
  logic [2*NW-1:0]   edge_wd, edge_rd;
  logic              stack_we;  logic [NW-1:0] stack_wa, stack_ra, stack_wd, stack_rd;
  logic              cursor_we; logic [NW-1:0] cursor_wa, cursor_ra, cursor_wd, cursor_rd;
  logic              depth_we;  logic [NW-1:0] depth_wa, depth_ra, depth_wd, depth_rd;
  logic              seen_we;   logic [NW-1:0] seen_wa, seen_ra;
  logic              seen_wd, seen_rd;
  logic              paint_we;  logic [NW-1:0] paint_wa, paint_ra;
  logic              paint_wd, paint_rd;
  logic              anc_we;    logic [LW+NW-1:0] anc_wa, anc_ra;
  logic [AW-1:0]     anc_wd, anc_rd;

  tnmd_ram #(.DATA_W(2*NW), .ADDR_W(NW), .DEPTH(MAX_NODES)) u_edge (
    .clk, .we(edge_we), .waddr(edge_wa), .wdata(edge_wd), .raddr(edge_ra), .rdata(edge_rd));
  tnmd_ram #(.DATA_W(NW), .ADDR_W(NW), .DEPTH(MAX_NODES)) u_stack (
    .clk, .we(stack_we), .waddr(stack_wa), .wdata(stack_wd), .raddr(stack_ra),
    .rdata(stack_rd));
  tnmd_ram #(.DATA_W(NW), .ADDR_W(NW), .DEPTH(MAX_NODES)) u_cursor (
    .clk, .we(cursor_we), .waddr(cursor_wa), .wdata(cursor_wd), .raddr(cursor_ra),
    .rdata(cursor_rd));
  tnmd_ram #(.DATA_W(NW), .ADDR_W(NW), .DEPTH(MAX_NODES)) u_depth (
    .clk, .we(depth_we), .waddr(depth_wa), .wdata(depth_wd), .raddr(depth_ra),
    .rdata(depth_rd));
  tnmd_ram #(.DATA_W(1), .ADDR_W(NW), .DEPTH(MAX_NODES)) u_seen (
    .clk, .we(seen_we), .waddr(seen_wa), .wdata(seen_wd), .raddr(seen_ra), .rdata(seen_rd));
  tnmd_ram #(.DATA_W(1), .ADDR_W(NW), .DEPTH(MAX_NODES)) u_paint (
    .clk, .we(paint_we), .waddr(paint_wa), .wdata(paint_wd), .raddr(paint_ra),
    .rdata(paint_rd));
  tnmd_ram #(.DATA_W(AW), .ADDR_W(LW+NW), .DEPTH(ANC_DEPTH)) u_anc (
    .clk, .we(anc_we), .waddr(anc_wa), .wdata(anc_wd), .raddr(anc_ra), .rdata(anc_rd));

  // request decode
  logic [XW-1:0] a_x, b_x, n_x, cfg_x;
  logic          a_ok, b_ok, in_take, edge_go, build_go, paint_go, query_go;
  logic [NW-1:0] a_n, b_n;

  assign in_stall = (state != tnmd_pkg::S_IDLE);
  assign a_x      = XW'(node_a);
  assign b_x      = XW'(node_b);
  assign n_x      = XW'(node_count);
  assign cfg_x    = XW'(cfg_wdata);
  assign a_n      = a_x[NW-1:0];
  assign b_n      = b_x[NW-1:0];
  assign a_ok     = a_x < n_x;
  assign b_ok     = b_x < n_x;
  assign in_take  = in_valid && !in_stall;
  assign edge_go  = in_take && kind == tnmd_pkg::KIND_EDGE && !ready && a_ok && b_ok;
  assign build_go = edge_go && (CW'(edges) + CW'(1) == node_count - CW'(1));
  assign paint_go = in_take && kind == tnmd_pkg::KIND_PAINT && a_ok;
  assign query_go = in_take && kind == tnmd_pkg::KIND_QUERY && ready && a_ok;

  // walk helpers
  logic [NW-1:0]  ea, eb, w_sel;
  logic           hit;
  logic [CW-1:0]  top_dn;
  logic [LCW-1:0] lvl_dn;
  assign ea     = edge_rd[2*NW-1:NW];
  assign eb     = edge_rd[NW-1:0];
  assign hit    = (ea == cur) || (eb == cur);
  assign w_sel  = (ea == cur) ? eb : ea;
  assign top_dn = top - CW'(1);
  assign lvl_dn = lvl - LCW'(1);

  // query helpers
  logic          v_deeper;
  logic [AW-1:0] y_anc;
  logic [DSW-1:0] dsum;
  logic [tnmd_pkg::DIST_W-1:0] dsat;
  assign v_deeper = da < depth_rd;
  assign y_anc    = (pv == NONE) ? NONE : anc_rd;
  assign dsum     = DSW'(du) + DSW'(dd) - (DSW'(depth_rd) << 1);
  assign dsat     = (dsum > DSW'(tnmd_pkg::DIST_MAX)) ? tnmd_pkg::DIST_MAX
                                                      : dsum[tnmd_pkg::DIST_W-1:0];

  logic out_busy, out_load;
  assign out_busy = out_valid && out_stall;
  assign out_load = (state == tnmd_pkg::Q_V) && (idx == node_count) && !out_busy;

  // RAM port steering
  always_comb begin
    edge_we = 1'b0;   edge_wa = '0;   edge_wd = '0;   edge_ra = '0;
    stack_we = 1'b0;  stack_wa = '0;  stack_wd = '0;  stack_ra = '0;
    cursor_we = 1'b0; cursor_wa = '0; cursor_wd = '0; cursor_ra = '0;
    depth_we = 1'b0;  depth_wa = '0;  depth_wd = '0;  depth_ra = '0;
    seen_we = 1'b0;   seen_wa = '0;   seen_wd = 1'b0; seen_ra = '0;
    paint_we = 1'b0;  paint_wa = '0;  paint_wd = 1'b0; paint_ra = '0;
    anc_we = 1'b0;    anc_wa = '0;    anc_wd = '0;    anc_ra = '0;
    unique case (state)
      tnmd_pkg::S_CLR: begin
        paint_we  = 1'b1; paint_wa  = idx[NW-1:0]; paint_wd = (idx == '0);
        seen_we   = 1'b1; seen_wa   = idx[NW-1:0]; seen_wd  = (idx == '0);
        cursor_we = 1'b1; cursor_wa = idx[NW-1:0];
        depth_we  = 1'b1; depth_wa  = idx[NW-1:0];
        anc_we    = 1'b1; anc_wa    = {LW'(0), idx[NW-1:0]}; anc_wd = NONE;
      end
      tnmd_pkg::S_IDLE: begin
        edge_we  = edge_go;  edge_wa  = edges; edge_wd = {a_n, b_n};
        stack_we = build_go;
        paint_we = paint_go; paint_wa = a_n;   paint_wd = 1'b1;
      end
      tnmd_pkg::B_POP:   stack_ra = top_dn[NW-1:0];
      tnmd_pkg::B_CUR: begin
        cursor_ra = stack_rd;
        depth_ra  = stack_rd;
      end
      tnmd_pkg::B_EDGE:  edge_ra = scan;
      tnmd_pkg::B_EDGE2: seen_ra = w_sel;
      tnmd_pkg::B_SEEN: begin
        if (!seen_rd) begin
          seen_we   = 1'b1; seen_wa   = wnode; seen_wd = 1'b1;
          depth_we  = 1'b1; depth_wa  = wnode; depth_wd = dcur + NW'(1);
          anc_we    = 1'b1; anc_wa    = {LW'(0), wnode}; anc_wd = {1'b0, cur};
          stack_we  = 1'b1; stack_wa  = top[NW-1:0]; stack_wd = wnode;
          cursor_we = 1'b1; cursor_wa = cur; cursor_wd = scan;
        end
      end
      tnmd_pkg::F_A: anc_ra = {lvl_dn[LW-1:0], idx[NW-1:0]};
      tnmd_pkg::F_B: begin
        if (anc_rd == NONE) begin
          anc_we = 1'b1; anc_wa = {lvl[LW-1:0], idx[NW-1:0]}; anc_wd = NONE;
        end else begin
          anc_ra = {lvl_dn[LW-1:0], anc_rd[NW-1:0]};
        end
      end
      tnmd_pkg::F_C: begin
        anc_we = 1'b1; anc_wa = {lvl[LW-1:0], idx[NW-1:0]}; anc_wd = anc_rd;
      end
      tnmd_pkg::Q_START: depth_ra = qa;
      tnmd_pkg::Q_V: begin
        paint_ra = idx[NW-1:0];
        depth_ra = idx[NW-1:0];
      end
      tnmd_pkg::Q_LIFT:  anc_ra = {lvl[LW-1:0], pu[NW-1:0]};
      tnmd_pkg::Q_CMP:   anc_ra = {lvl[LW-1:0], pu[NW-1:0]};
      tnmd_pkg::Q_CMP2:  anc_ra = {lvl[LW-1:0], pv[NW-1:0]};
      tnmd_pkg::Q_PAR:   anc_ra = {LW'(0), pu[NW-1:0]};
      tnmd_pkg::Q_AD:    depth_ra = la[NW-1:0];
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tnmd_pkg::S_CLR;
      idx        <= '0;
      node_count <= CW'(2);
      edges      <= '0;
      ready      <= 1'b0;
      top        <= '0;
      lvl        <= '0;
      out_valid  <= 1'b0;
    end else begin
      // node_count is frozen once loading starts; clamp to the legal range
      if (cfg_we && !ready && edges == '0) begin
        if (cfg_x < XW'(tnmd_pkg::NODES_MIN)) begin
          node_count <= CW'(2);
        end else if (cfg_x > XW'(MAX_NODES)) begin
          node_count <= CW'(MAX_NODES);
        end else begin
          node_count <= cfg_x[CW-1:0];
        end
      end
      // load a finished distance, or drop the one just taken
      if (out_load) begin
        out_valid <= 1'b1;
        distance  <= best;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        tnmd_pkg::S_CLR: begin
          if (idx == CW'(MAX_NODES - 1)) begin
            idx   <= '0;
            state <= tnmd_pkg::S_IDLE;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        tnmd_pkg::S_IDLE: begin
          if (edge_go) begin
            edges <= edges + NW'(1);
          end
          if (build_go) begin
            top   <= CW'(1);
            state <= tnmd_pkg::B_POP;
          end
          if (query_go) begin
            qa    <= a_n;
            state <= tnmd_pkg::Q_START;
          end
        end
        // depth-first walk from node 0, one stack frame at a time
        tnmd_pkg::B_POP: begin
          if (top == '0) begin
            if (LIFT_LEVELS > 1) begin
              lvl   <= LCW'(1);
              idx   <= '0;
              state <= tnmd_pkg::F_A;
            end else begin
              ready <= 1'b1;
              state <= tnmd_pkg::S_IDLE;
            end
          end else begin
            state <= tnmd_pkg::B_CUR;
          end
        end
        tnmd_pkg::B_CUR: begin
          cur   <= stack_rd;
          state <= tnmd_pkg::B_SCAN;
        end
        tnmd_pkg::B_SCAN: begin
          scan  <= cursor_rd;
          dcur  <= depth_rd;
          state <= tnmd_pkg::B_EDGE;
        end
        tnmd_pkg::B_EDGE: begin
          if (scan >= edges) begin
            top   <= top_dn;
            state <= tnmd_pkg::B_POP;
          end else begin
            scan  <= scan + NW'(1);
            state <= tnmd_pkg::B_EDGE2;
          end
        end
        tnmd_pkg::B_EDGE2: begin
          if (hit) begin
            wnode <= w_sel;
            state <= tnmd_pkg::B_SEEN;
          end else begin
            state <= tnmd_pkg::B_EDGE;
          end
        end
        tnmd_pkg::B_SEEN: begin
          if (!seen_rd) begin
            top   <= top + CW'(1);
            state <= tnmd_pkg::B_POP;
          end else begin
            state <= tnmd_pkg::B_EDGE;
          end
        end
        // ancestor table fill, level by level
        tnmd_pkg::F_A: state <= tnmd_pkg::F_B;
        tnmd_pkg::F_B, tnmd_pkg::F_C: begin
          if (state == tnmd_pkg::F_B && anc_rd != NONE) begin
            state <= tnmd_pkg::F_C;
          end else if (idx + CW'(1) == node_count) begin
            idx <= '0;
            if (lvl == LCW'(LIFT_LEVELS - 1)) begin
              ready <= 1'b1;
              state <= tnmd_pkg::S_IDLE;
            end else begin
              lvl   <= lvl + LCW'(1);
              state <= tnmd_pkg::F_A;
            end
          end else begin
            idx   <= idx + CW'(1);
            state <= tnmd_pkg::F_A;
          end
        end
        // query: scan every node, measure each painted one
        tnmd_pkg::Q_START: state <= tnmd_pkg::Q_DA;
        tnmd_pkg::Q_DA: begin
          da    <= depth_rd;
          idx   <= '0;
          best  <= tnmd_pkg::DIST_MAX;
          state <= tnmd_pkg::Q_V;
        end
        tnmd_pkg::Q_V: begin
          if (idx == node_count) begin
            // hold here until the output register is free
            if (!out_busy) begin
              state <= tnmd_pkg::S_IDLE;
            end
          end else begin
            state <= tnmd_pkg::Q_P;
          end
        end
        tnmd_pkg::Q_P: begin
          if (!paint_rd) begin
            idx   <= idx + CW'(1);
            state <= tnmd_pkg::Q_V;
          end else begin
            if (v_deeper) begin
              pu <= {1'b0, idx[NW-1:0]}; pv <= {1'b0, qa};
              du <= depth_rd;            dd <= da;
              k  <= depth_rd - da;
            end else begin
              pu <= {1'b0, qa};          pv <= {1'b0, idx[NW-1:0]};
              du <= da;                  dd <= depth_rd;
              k  <= da - depth_rd;
            end
            lvl   <= '0;
            state <= tnmd_pkg::Q_LIFT;
          end
        end
        tnmd_pkg::Q_LIFT: begin
          if (k == '0 || lvl == LCW'(LIFT_LEVELS)) begin
            if (pu == pv) begin
              la    <= pu;
              state <= tnmd_pkg::Q_AD;
            end else begin
              lvl   <= LCW'(LIFT_LEVELS - 1);
              state <= tnmd_pkg::Q_CMP;
            end
          end else if (k[0]) begin
            state <= tnmd_pkg::Q_LIFT_W;
          end else begin
            k   <= k >> 1;
            lvl <= lvl + LCW'(1);
          end
        end
        tnmd_pkg::Q_LIFT_W: begin
          pu    <= (pu == NONE) ? NONE : anc_rd;
          k     <= k >> 1;
          lvl   <= lvl + LCW'(1);
          state <= tnmd_pkg::Q_LIFT;
        end
        tnmd_pkg::Q_CMP:  state <= tnmd_pkg::Q_CMP2;
        tnmd_pkg::Q_CMP2: begin
          xa    <= (pu == NONE) ? NONE : anc_rd;
          state <= tnmd_pkg::Q_CMP_W;
        end
        tnmd_pkg::Q_CMP_W: begin
          if (xa != y_anc) begin
            pu <= xa;
            pv <= y_anc;
          end
          if (lvl == '0) begin
            state <= tnmd_pkg::Q_PAR;
          end else begin
            lvl   <= lvl_dn;
            state <= tnmd_pkg::Q_CMP;
          end
        end
        tnmd_pkg::Q_PAR:   state <= tnmd_pkg::Q_PAR_W;
        tnmd_pkg::Q_PAR_W: begin
          la    <= (pu == NONE) ? NONE : anc_rd;
          state <= tnmd_pkg::Q_AD;
        end
        tnmd_pkg::Q_AD: begin
          // no common ancestor: distance saturates, never beats best
          if (la == NONE) begin
            idx   <= idx + CW'(1);
            state <= tnmd_pkg::Q_V;
          end else begin
            state <= tnmd_pkg::Q_AD_W;
          end
        end
        tnmd_pkg::Q_AD_W: begin
          if (dsat < best) begin
            best <= dsat;
          end
          idx   <= idx + CW'(1);
          state <= tnmd_pkg::Q_V;
        end
        default: state <= tnmd_pkg::S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/tnmd_check.sv =====
// Port-level checker for tree_nearest_marked_distance, with its bind.
// Depends on tnmd_pkg.
module tnmd_check (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic [tnmd_pkg::KIND_W-1:0] kind,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [tnmd_pkg::DIST_W-1:0] distance
);

  // clearing pass holds off requests right after reset
  a_clear_stall: assert property (@(posedge clk) rst |=> in_stall)
    else $error("request taken during clearing pass");

  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown after reset");

  // paint and unused kinds finish in the accepting cycle
  a_paint_quick: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall &&
     (kind == tnmd_pkg::KIND_PAINT || kind == tnmd_pkg::KIND_SPARE)) |=> !in_stall)
    else $error("paint request held the block");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(distance)))
    else $error("stalled result changed");

endmodule

bind tree_nearest_marked_distance tnmd_check u_tnmd_check (
  .clk, .rst, .in_valid, .in_stall, .kind, .out_valid, .out_stall, .distance);

// ===== test/tnmd_checker.sv =====
`timescale 1ns / 100ps
// Checker for tree_nearest_marked_distance: watches request, result and
// config traffic, predicts distances and compares. Depends on tnmd_pkg.
module tnmd_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [tnmd_pkg::KIND_W-1:0] kind,
  input  logic [tnmd_pkg::NODE_W-1:0] node_a,
  input  logic [tnmd_pkg::NODE_W-1:0] node_b,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [tnmd_pkg::DIST_W-1:0] distance,
  input  logic                        cfg_we,
  input  logic [tnmd_pkg::CFG_W-1:0]  cfg_wdata,
  output int                          fail_count,
  output int                          pending
);

  localparam int NODES     = 1024;
  localparam int LEVELS    = 11;
  localparam int NONE      = NODES;
  localparam int DUE_DEPTH = 16;
  localparam int DMAX      = int'(tnmd_pkg::DIST_MAX);

  int nodes_used;
  int edge_lo [NODES];
  int edge_hi [NODES];
  int edge_total;
  int depth_of [NODES];
  int anc [LEVELS][NODES];
  bit painted [NODES];
  bit built;
  logic [tnmd_pkg::DIST_W-1:0] due_mem [DUE_DEPTH];
  int due_wr, due_rd, due_count;

  function automatic int hop(int u, int l);
    if (u >= NODES) return NONE;
    return anc[l][u];
  endfunction

  function automatic void root_tree();
    int stack_arr [NODES];
    int cursor [NODES];
    bit seen [NODES];
    int sp, cur, i, w, u, l;
    bit pushed;
    for (u = 0; u < NODES; u++) begin
      cursor[u] = 0;
      seen[u] = 0;
    end
    for (u = 0; u < nodes_used; u++) begin
      depth_of[u] = 0;
      anc[0][u] = NONE;
    end
    seen[0] = 1;
    stack_arr[0] = 0;
    sp = 1;
    while (sp > 0) begin
      cur = stack_arr[sp - 1];
      pushed = 0;
      while (cursor[cur] < edge_total && !pushed) begin
        i = cursor[cur];
        cursor[cur]++;
        if (edge_lo[i] == cur) w = edge_hi[i];
        else if (edge_hi[i] == cur) w = edge_lo[i];
        else continue;
        if (w < nodes_used && !seen[w] && sp < NODES) begin
          seen[w] = 1;
          depth_of[w] = depth_of[cur] + 1;
          anc[0][w] = cur;
          stack_arr[sp] = w;
          sp++;
          pushed = 1;
        end
      end
      if (!pushed) sp--;
    end
    for (l = 1; l < LEVELS; l++)
      for (u = 0; u < nodes_used; u++)
        anc[l][u] = hop(hop(u, l - 1), l - 1);
    built = 1;
  endfunction

  function automatic int tree_gap(int u, int v);
    int du, dv, t, k, l, x, y, a, d;
    du = depth_of[u];
    dv = depth_of[v];
    if (du < dv) begin
      t = u; u = v; v = t;
      t = du; du = dv; dv = t;
    end
    k = du - dv;
    for (l = 0; l < LEVELS && k != 0; l++) begin
      if (k & 1) u = hop(u, l);
      k = k >> 1;
    end
    if (u == v) begin
      a = u;
    end else begin
      for (l = LEVELS - 1; l >= 0; l--) begin
        x = hop(u, l);
        y = hop(v, l);
        if (x != y) begin
          u = x;
          v = y;
        end
      end
      a = hop(u, 0);
    end
    if (a >= NODES) return DMAX;
    d = du + dv - 2 * depth_of[a];
    return (d > DMAX) ? DMAX : d;
  endfunction

  function automatic logic [tnmd_pkg::DIST_W-1:0] nearest_painted(int u);
    int best, v, d;
    best = DMAX;
    for (v = 0; v < nodes_used; v++)
      if (painted[v]) begin
        d = tree_gap(u, v);
        if (d < best) best = d;
      end
    return best[tnmd_pkg::DIST_W-1:0];
  endfunction

  assign pending = due_count;

  always @(posedge clk) begin
    int a, b, w;
    if (rst) begin
      nodes_used = 2;
      edge_total = 0;
      built = 0;
      for (a = 0; a < NODES; a++) painted[a] = 0;
      painted[0] = 1;
      due_wr = 0;
      due_rd = 0;
      due_count = 0;
      fail_count <= 0;
    end else begin
      if (cfg_we && !built && edge_total == 0) begin
        w = int'(cfg_wdata);
        if (w < 2) w = 2;
        if (w > NODES) w = NODES;
        nodes_used = w;
      end
      if (in_valid && !in_stall) begin
        a = int'(node_a);
        b = int'(node_b);
        case (kind)
          tnmd_pkg::KIND_EDGE: begin
            if (!built && a < nodes_used && b < nodes_used) begin
              if (edge_total < nodes_used - 1) begin
                edge_lo[edge_total] = a;
                edge_hi[edge_total] = b;
                edge_total++;
              end
              if (edge_total >= nodes_used - 1) root_tree();
            end
          end
          tnmd_pkg::KIND_PAINT: if (a < nodes_used) painted[a] = 1;
          tnmd_pkg::KIND_QUERY: begin
            if (built && a < nodes_used) begin
              due_mem[due_wr] = nearest_painted(a);
              due_wr = (due_wr + 1) % DUE_DEPTH;
              due_count++;
            end
          end
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (due_count == 0) begin
          $error("distance: unexpected result %0d", distance);
          fail_count <= fail_count + 1;
        end else begin
          if (distance !== due_mem[due_rd]) begin
            $error("distance: expected %0d, actual %0d", due_mem[due_rd], distance);
            fail_count <= fail_count + 1;
          end
          due_rd = (due_rd + 1) % DUE_DEPTH;
          due_count--;
        end
      end
    end
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Testbench top for tree_nearest_marked_distance: clock, reset, requests,
// config writes and verdict. Depends on tnmd_pkg, tnmd_checker and tree_nearest_marked_distance.
module tb;

  // Tree size used for the single build this run can do.
  localparam int TREE_NODES = 40;
  // Cycles with no handshake before the run is declared hung.
  localparam int IDLE_LIMIT = 200000;

  logic                        clk = 0;
  logic                        rst = 1;
  logic                        in_valid = 0;
  logic                        in_stall;
  logic [tnmd_pkg::KIND_W-1:0] kind = tnmd_pkg::KIND_EDGE;
  logic [tnmd_pkg::NODE_W-1:0] node_a = '0;
  logic [tnmd_pkg::NODE_W-1:0] node_b = '0;
  logic                        out_valid;
  logic                        out_stall = 0;
  logic [tnmd_pkg::DIST_W-1:0] distance;
  logic                        cfg_we = 0;
  logic [tnmd_pkg::CFG_W-1:0]  cfg_wdata = '0;
  int                          fail_count;
  int                          pending;
  int                          burst_left = 0;
  int                          quiet_cycles = 0;
  int                          tree_order [TREE_NODES-1];
  int                          parent_of [TREE_NODES];

  always #1 clk = ~clk;

  tree_nearest_marked_distance u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .node_a(node_a), .node_b(node_b),
    .out_valid(out_valid), .out_stall(out_stall), .distance(distance),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  tnmd_checker u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .node_a(node_a), .node_b(node_b),
    .out_valid(out_valid), .out_stall(out_stall), .distance(distance),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  // Receiver: switch stall pattern by simulation time - none, coin flip, or
  // long holds - so stalls land on every phase of a query.
  always @(posedge clk) begin
    int mode;
    if (rst) begin
      out_stall <= 0;
    end else begin
      mode = int'(($time / 128) % 3);
      case (mode)
        0: out_stall <= 0;
        1: out_stall <= ($urandom_range(0, 1) != 0);
        default: out_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Watchdog: count cycles in which neither channel moves.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Present one request and hold it until the block takes it. Gaps come
  // between bursts of random length; within a burst valid stays high.
  task automatic push_request(input logic [tnmd_pkg::KIND_W-1:0] k, input int a,
                              input int b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1;
    kind <= k;
    node_a <= a[tnmd_pkg::NODE_W-1:0];
    node_b <= b[tnmd_pkg::NODE_W-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  // Drop valid, drain all expected distances, then let a build or query
  // with no result finish before touching config.
  task automatic settle(input int extra);
    in_valid <= 0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_nodes(input int value);
    cfg_we <= 1;
    cfg_wdata <= value[tnmd_pkg::CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  initial begin
    int i, j, pick, broken, r, a, t;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Hold off until the clearing pass lets requests through.
    while (in_stall) @(posedge clk);

    // Sweep node_count through clamping at both ends, then settle on the tree size.
    write_nodes(0);
    write_nodes(2047);
    write_nodes(1);
    write_nodes(1024);
    write_nodes(TREE_NODES);

    // Before the build: queries give nothing, paint is kept, junk is dropped.
    push_request(tnmd_pkg::KIND_QUERY, 0, 1023);
    push_request(tnmd_pkg::KIND_PAINT, 5, 0);
    push_request(tnmd_pkg::KIND_PAINT, 1023, 1023);
    push_request(tnmd_pkg::KIND_SPARE, 1023, 1023);
    push_request(tnmd_pkg::KIND_EDGE, 1023, 1);
    push_request(tnmd_pkg::KIND_EDGE, 2, 1023);
    push_request(tnmd_pkg::KIND_EDGE, TREE_NODES, 0);

    // Random tree; one edge becomes a self loop so a subtree is cut off.
    for (i = 0; i < TREE_NODES - 1; i++) tree_order[i] = i + 1;
    for (i = TREE_NODES - 2; i > 0; i--) begin
      pick = $urandom_range(0, i);
      t = tree_order[i];
      tree_order[i] = tree_order[pick];
      tree_order[pick] = t;
    end
    for (i = 0; i < TREE_NODES - 1; i++) begin
      pick = $urandom_range(0, i);
      parent_of[i] = (pick == i) ? 0 : tree_order[pick];
    end
    broken = $urandom_range(3, TREE_NODES - 2);
    for (i = 0; i < TREE_NODES - 1; i++) begin
      if (i == broken) begin
        push_request(tnmd_pkg::KIND_EDGE, tree_order[i], tree_order[i]);
      end else if ($urandom_range(0, 1)) begin
        push_request(tnmd_pkg::KIND_EDGE, tree_order[i], parent_of[i]);
      end else begin
        push_request(tnmd_pkg::KIND_EDGE, parent_of[i], tree_order[i]);
      end
      if (i % 9 == 4) push_request(tnmd_pkg::KIND_QUERY, tree_order[i], $urandom);
    end

    // After the build: late edge, double paint, range limits.
    push_request(tnmd_pkg::KIND_EDGE, 1, 2);
    push_request(tnmd_pkg::KIND_QUERY, 0, 0);
    push_request(tnmd_pkg::KIND_QUERY, TREE_NODES - 1, 1023);
    push_request(tnmd_pkg::KIND_QUERY, TREE_NODES, 0);
    push_request(tnmd_pkg::KIND_QUERY, 1023, 0);
    push_request(tnmd_pkg::KIND_PAINT, 0, 0);
    push_request(tnmd_pkg::KIND_QUERY, tree_order[broken], 0);
    push_request(tnmd_pkg::KIND_PAINT, TREE_NODES - 1, 0);
    push_request(tnmd_pkg::KIND_QUERY, 5, 0);

    // Random mix, mostly in-range paint and query; config writes between
    // halves must bounce off the built tables.
    for (j = 0; j < 2; j++) begin
      settle(3000);
      write_nodes(j == 0 ? 2 : 1024);
      for (i = 0; i < 115; i++) begin
        r = $urandom_range(0, 99);
        a = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                          : $urandom_range(0, TREE_NODES - 1);
        if (r < 60) begin
          push_request(tnmd_pkg::KIND_QUERY, a, $urandom);
        end else if (r < 75 - 5 * i / 30) begin
          push_request(tnmd_pkg::KIND_PAINT, a, $urandom);
        end else if (r < 95) begin
          push_request(tnmd_pkg::KIND_QUERY, $urandom_range(0, TREE_NODES - 1), $urandom);
        end else if (r < 98) begin
          push_request(tnmd_pkg::KIND_SPARE, $urandom, $urandom);
        end else begin
          push_request(tnmd_pkg::KIND_EDGE, a, $urandom);
        end
      end
    end

    settle(3000);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== tree_nearest_marked_distance.f =====
rtl/tnmd_pkg.sv
rtl/tnmd_ram.sv
rtl/tree_nearest_marked_distance.sv
rtl/tnmd_check.sv
test/tnmd_checker.sv
test/tb.sv
